// ===== design/multidrop_9bit_frame_assembler_defines.svh =====
// assertion macros shared by the frame assembler rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef MULTIDROP_9BIT_FRAME_ASSEMBLER_DEFINES_SVH
`define MULTIDROP_9BIT_FRAME_ASSEMBLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MDFA_CHECK(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked outside reset
`define MDFA_CHECK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/mdfa_pkg.sv =====
// shared constants, state encodings and inter-module structs of the frame assembler
// no dependencies
`default_nettype none

package mdfa_pkg;

  localparam int PAYLOAD_MAX = 64;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = 6;
  localparam int LEN_W       = 7;
  localparam int CNT_W       = 16;

  localparam logic [7:0] ADDR_ALL = 8'hFF;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    EM_IDLE  = 2'd0,
    EM_EMPTY = 2'd1,
    EM_DATA  = 2'd2
  } emit_state_t;

  // completed frame handed from parser to emitter
  typedef struct packed {
    logic             done;
    logic [7:0]       address;
    logic [LEN_W-1:0] length;
    logic [CNT_W-1:0] dropped;
  } frame_desc_t;

  // payload store write port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

endpackage

`default_nettype wire

// ===== design/mdfa_in_if.sv =====
// received word channel: valid/ready plus the 9-bit word and its error flag
// no dependencies
`default_nettype none

interface mdfa_in_if;
  logic       valid;
  logic       ready;
  logic       is_address_word;
  logic [7:0] word_byte;
  logic       receive_error;

  modport source (output valid, is_address_word, word_byte, receive_error, input ready);
  modport sink   (input valid, is_address_word, word_byte, receive_error, output ready);
endinterface

`default_nettype wire

// ===== design/mdfa_out_if.sv =====
// frame byte result channel: valid/ready plus one payload byte and its frame info
// depends on mdfa_pkg for field widths
`default_nettype none

interface mdfa_out_if;
  logic                      valid;
  logic                      ready;
  logic [7:0]                frame_address;
  logic [mdfa_pkg::LEN_W-1:0] frame_length;
  logic [mdfa_pkg::ADDR_W-1:0] byte_index;
  logic [7:0]                payload_byte;
  logic                      has_byte;
  logic                      last;
  logic [mdfa_pkg::CNT_W-1:0] dropped_words;

  modport source (output valid, frame_address, frame_length, byte_index, payload_byte,
                  has_byte, last, dropped_words, input ready);
  modport sink   (input valid, frame_address, frame_length, byte_index, payload_byte,
                  has_byte, last, dropped_words, output ready);
endinterface

`default_nettype wire

// ===== design/mdfa_cfg_if.sv =====
// configuration write channel carrying the listen address
// no dependencies
`default_nettype none

interface mdfa_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] listen_address;

  modport source (output valid, listen_address, input ready);
  modport sink   (input valid, listen_address, output ready);
endinterface

`default_nettype wire

// ===== design/mdfa_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module mdfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/mdfa_parse.sv =====
// word parser: error count, address match, length check and payload store writes
// depends on mdfa_pkg, mdfa_in_if and mdfa_cfg_if
`default_nettype none

module mdfa_parse (
  input  wire logic           clk,
  input  wire logic           rst_n,
  mdfa_in_if.sink             in_ch,
  mdfa_cfg_if.sink            cfg_ch,
  input  wire logic           emit_busy,
  output mdfa_pkg::frame_desc_t desc,
  output mdfa_pkg::store_wr_t   wr
);

  mdfa_pkg::phase_t               phase_r, phase_nxt;
  logic [7:0]                     listen_r, listen_nxt;
  logic [7:0]                     held_r, held_nxt;
  logic [mdfa_pkg::LEN_W-1:0]     exp_r, exp_nxt;
  logic [mdfa_pkg::LEN_W-1:0]     rcv_r, rcv_nxt;
  logic [mdfa_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           done_r, done_nxt;

  logic                           in_xfer;
  logic                           cfg_xfer;
  logic                           data_xfer;
  logic                           addr_match;
  logic                           len_ok;
  logic [mdfa_pkg::LEN_W-1:0]     rcv_inc;

  assign in_ch.ready  = !emit_busy && !done_r;
  assign cfg_ch.ready = 1'b1;

  assign in_xfer    = in_ch.valid && in_ch.ready;
  assign cfg_xfer   = cfg_ch.valid && cfg_ch.ready;
  assign data_xfer  = in_xfer && !in_ch.receive_error && !in_ch.is_address_word;
  assign addr_match = (listen_r == mdfa_pkg::ADDR_ALL) || (in_ch.word_byte == listen_r);
  assign len_ok     = in_ch.word_byte <= 8'(mdfa_pkg::PAYLOAD_MAX);
  assign rcv_inc    = rcv_r + mdfa_pkg::LEN_W'(1);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (cfg_xfer) begin
      phase_nxt = mdfa_pkg::PH_IDLE;
    end else if (in_xfer && !in_ch.receive_error) begin
      if (in_ch.is_address_word) begin
        phase_nxt = addr_match ? mdfa_pkg::PH_LENGTH : mdfa_pkg::PH_IDLE;
      end else begin
        case (phase_r)
          mdfa_pkg::PH_LENGTH: begin
            if (!len_ok || (in_ch.word_byte == 8'd0)) begin
              phase_nxt = mdfa_pkg::PH_IDLE;
            end else begin
              phase_nxt = mdfa_pkg::PH_PAYLOAD;
            end
          end
          mdfa_pkg::PH_PAYLOAD: begin
            if (rcv_inc >= exp_r) begin
              phase_nxt = mdfa_pkg::PH_IDLE;
            end
          end
          default: phase_nxt = mdfa_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // datapath and store writes
  always_comb begin
    listen_nxt = listen_r;
    held_nxt   = held_r;
    exp_nxt    = exp_r;
    rcv_nxt    = rcv_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    wr.we      = 1'b0;
    wr.addr    = rcv_r[mdfa_pkg::ADDR_W-1:0];
    wr.data    = in_ch.word_byte;
    if (cfg_xfer) begin
      listen_nxt = cfg_ch.listen_address;
    end
    if (in_xfer && in_ch.receive_error && (cnt_r != '1)) begin
      cnt_nxt = cnt_r + mdfa_pkg::CNT_W'(1);
    end
    if (in_xfer && !in_ch.receive_error && in_ch.is_address_word && addr_match) begin
      held_nxt = in_ch.word_byte;
    end
    case (phase_r)
      mdfa_pkg::PH_LENGTH: begin
        if (data_xfer && len_ok) begin
          exp_nxt  = in_ch.word_byte[mdfa_pkg::LEN_W-1:0];
          rcv_nxt  = '0;
          done_nxt = in_ch.word_byte == 8'd0;
        end
      end
      mdfa_pkg::PH_PAYLOAD: begin
        if (data_xfer) begin
          wr.we    = 1'b1;
          rcv_nxt  = rcv_inc;
          done_nxt = rcv_inc >= exp_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= mdfa_pkg::PH_IDLE;
      listen_r <= mdfa_pkg::ADDR_ALL;
      held_r   <= '0;
      exp_r    <= '0;
      rcv_r    <= '0;
      cnt_r    <= '0;
      done_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      listen_r <= listen_nxt;
      held_r   <= held_nxt;
      exp_r    <= exp_nxt;
      rcv_r    <= rcv_nxt;
      cnt_r    <= cnt_nxt;
      done_r   <= done_nxt;
    end
  end

  assign desc.done    = done_r;
  assign desc.address = held_r;
  assign desc.length  = exp_r;
  assign desc.dropped = cnt_r;

endmodule

`default_nettype wire

// ===== design/mdfa_emit.sv =====
// frame emitter: walks the payload store one byte a cycle into the output register while that register is free
// depends on mdfa_pkg and mdfa_out_if
`default_nettype none

module mdfa_emit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mdfa_pkg::frame_desc_t         desc,
  output logic                               busy,
  output logic                               rd_en,
  output logic [mdfa_pkg::ADDR_W-1:0]        rd_addr,
  input  wire logic [7:0]                    rd_data,
  mdfa_out_if.source                         out_ch
);

  mdfa_pkg::emit_state_t          state_r, state_nxt;
  logic [mdfa_pkg::ADDR_W-1:0]    idx_r, idx_nxt;

  logic                           ov_r, ov_nxt;
  logic [7:0]                     o_addr_r;
  logic [mdfa_pkg::LEN_W-1:0]     o_len_r;
  logic [mdfa_pkg::ADDR_W-1:0]    o_idx_r;
  logic [7:0]                     o_data_r;
  logic                           o_has_r;
  logic                           o_last_r;
  logic [mdfa_pkg::CNT_W-1:0]     o_drop_r;

  logic                           slot_free;
  logic                           idx_last;
  logic                           load;
  logic                           ld_has;
  logic                           ld_last;
  logic [7:0]                     ld_data;

  assign slot_free = !ov_r || out_ch.ready;
  assign idx_last  = (mdfa_pkg::LEN_W'(idx_r) + mdfa_pkg::LEN_W'(1)) == desc.length;
  assign busy      = state_r != mdfa_pkg::EM_IDLE;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mdfa_pkg::EM_IDLE: begin
        if (desc.done) begin
          state_nxt = (desc.length == '0) ? mdfa_pkg::EM_EMPTY : mdfa_pkg::EM_DATA;
        end
      end
      mdfa_pkg::EM_EMPTY: begin
        if (slot_free) begin
          state_nxt = mdfa_pkg::EM_IDLE;
        end
      end
      mdfa_pkg::EM_DATA: begin
        if (slot_free && idx_last) begin
          state_nxt = mdfa_pkg::EM_IDLE;
        end
      end
      default: state_nxt = mdfa_pkg::EM_IDLE;
    endcase
  end

  // store reads and output loads; next read goes out as the current byte loads
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r;
    idx_nxt = idx_r;
    load    = 1'b0;
    ld_has  = 1'b0;
    ld_last = 1'b0;
    ld_data = 8'd0;
    case (state_r)
      mdfa_pkg::EM_IDLE: begin
        if (desc.done) begin
          idx_nxt = '0;
          if (desc.length != '0) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end
      mdfa_pkg::EM_EMPTY: begin
        load    = slot_free;
        ld_last = 1'b1;
      end
      mdfa_pkg::EM_DATA: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_has  = 1'b1;
          ld_last = idx_last;
          ld_data = rd_data;
          if (!idx_last) begin
            idx_nxt = idx_r + mdfa_pkg::ADDR_W'(1);
            rd_en   = 1'b1;
            rd_addr = idx_nxt;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mdfa_pkg::EM_IDLE;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_addr_r <= desc.address;
      o_len_r  <= desc.length;
      o_idx_r  <= idx_r;
      o_data_r <= ld_data;
      o_has_r  <= ld_has;
      o_last_r <= ld_last;
      o_drop_r <= desc.dropped;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.frame_address = o_addr_r;
  assign out_ch.frame_length  = o_len_r;
  assign out_ch.byte_index    = o_idx_r;
  assign out_ch.payload_byte  = o_data_r;
  assign out_ch.has_byte      = o_has_r;
  assign out_ch.last          = o_last_r;
  assign out_ch.dropped_words = o_drop_r;

endmodule

`default_nettype wire

// ===== design/multidrop_9bit_frame_assembler.sv =====
// Nine-bit multidrop receive deframer. Takes one received word per cycle while no frame
// is being emitted; payload bytes go into a 64-entry synchronous ram. Once the last
// payload byte (or a zero length byte) is taken, input stalls while the emitter reads
// the ram through its single read port, one byte per cycle while the output register
// is free; output stalls hold off input too. The last result of a frame may still
// wait in the output register while new words are taken. Words with a receive error
// are dropped and counted, saturating at 65535. Writing the listen address (255
// listens to all stations) drops any half-parsed frame; write it only while the block
// is idle. No clearing pass after reset.
//
// depends on mdfa_pkg, the three channel interfaces, mdfa_ram, mdfa_parse, mdfa_emit
`default_nettype none

`include "multidrop_9bit_frame_assembler_defines.svh"

module multidrop_9bit_frame_assembler (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mdfa_in_if.sink    in_ch,
  mdfa_out_if.source out_ch,
  mdfa_cfg_if.sink   cfg_ch
);

  mdfa_pkg::frame_desc_t        desc;
  mdfa_pkg::store_wr_t          wr;
  logic                         emit_busy;
  logic                         rd_en;
  logic [mdfa_pkg::ADDR_W-1:0]  rd_addr;
  logic [7:0]                   rd_data;

  mdfa_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .emit_busy (emit_busy),
    .desc      (desc),
    .wr        (wr)
  );

  mdfa_ram #(
    .WIDTH (8),
    .DEPTH (mdfa_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mdfa_emit u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .desc    (desc),
    .busy    (emit_busy),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .out_ch  (out_ch)
  );

  `MDFA_CHECK(a_store_port, wr.we, !rd_en, "payload store written while emitter reads")
  `MDFA_CHECK_NEXT(a_done_blocks, desc.done, !in_ch.ready,
                   "input taken during frame emission")
  `MDFA_CHECK(a_empty_frame, out_ch.valid && !out_ch.has_byte,
              out_ch.last && (out_ch.frame_length == 7'd0), "empty result not a lone last")
  `MDFA_CHECK(a_last_index, out_ch.valid && out_ch.has_byte && out_ch.last,
              (7'(out_ch.byte_index) + 7'd1) == out_ch.frame_length, "last mark on wrong byte")

endmodule

`default_nettype wire

// ===== tb/sv/multidrop_9bit_frame_assembler_checker.sv =====
// passive checker for the 9-bit multidrop frame assembler: watches all three channels,
// predicts the frame bytes from the accepted words and compares each result transfer
// depends on mdfa_pkg and the three channel interfaces
`timescale 1ns / 100ps

module multidrop_9bit_frame_assembler_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  mdfa_in_if        in_ch,
  mdfa_out_if       out_ch,
  mdfa_cfg_if       cfg_ch,
  output int        pending,
  output int        failures
);
  import mdfa_pkg::*;

  typedef struct packed {
    logic [7:0]        address;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] index;
    logic [7:0]        data;
    logic              has_byte;
    logic              last;
    logic [CNT_W-1:0]  dropped;
  } frame_byte_t;

  frame_byte_t bytes_due[$];

  logic [7:0]       listen_addr;
  phase_t           phase;
  logic [7:0]       held_addr;
  logic [LEN_W-1:0] want_len;
  logic [LEN_W-1:0] got_len;
  logic [7:0]       store [STORE_DEPTH];
  logic [CNT_W-1:0] drop_count;

  task automatic push_frame_byte(input int idx, input logic [7:0] data, input logic has,
                                 input logic last);
    frame_byte_t fb;
    fb.address  = held_addr;
    fb.length   = want_len;
    fb.index    = ADDR_W'(idx);
    fb.data     = data;
    fb.has_byte = has;
    fb.last     = last;
    fb.dropped  = drop_count;
    bytes_due.push_back(fb);
  endtask

  // one accepted received word through the deframer
  task automatic deframe_word(input logic is_addr, input logic [7:0] b, input logic err);
    int i;
    if (err) begin
      if (drop_count != '1) drop_count = drop_count + 1'b1;
    end else if (is_addr) begin
      // an address word always ends a frame in progress
      if (listen_addr == ADDR_ALL || b == listen_addr) begin
        held_addr = b;
        phase = PH_LENGTH;
      end else begin
        phase = PH_IDLE;
      end
    end else if (phase == PH_LENGTH) begin
      if (b > PAYLOAD_MAX) begin
        phase = PH_IDLE;
      end else begin
        want_len = LEN_W'(b);
        got_len = '0;
        if (b == 0) begin
          phase = PH_IDLE;
          push_frame_byte(0, 8'h00, 1'b0, 1'b1);
        end else begin
          phase = PH_PAYLOAD;
        end
      end
    end else if (phase == PH_PAYLOAD) begin
      store[got_len[ADDR_W-1:0]] = b;
      got_len = got_len + 1'b1;
      if (got_len >= want_len) begin
        phase = PH_IDLE;
        for (i = 0; i < int'(want_len); i++)
          push_frame_byte(i, store[i], 1'b1, (i + 1 == int'(want_len)));
      end
    end else begin
      phase = PH_IDLE;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    frame_byte_t seen;
    frame_byte_t want;
    if (!rst_n) begin
      listen_addr = ADDR_ALL;
      phase = PH_IDLE;
      held_addr = '0;
      want_len = '0;
      got_len = '0;
      drop_count = '0;
      bytes_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        listen_addr = cfg_ch.listen_address;
        phase = PH_IDLE;
      end
      if (in_ch.valid && in_ch.ready)
        deframe_word(in_ch.is_address_word, in_ch.word_byte, in_ch.receive_error);
      if (out_ch.valid && out_ch.ready) begin
        seen.address  = out_ch.frame_address;
        seen.length   = out_ch.frame_length;
        seen.index    = out_ch.byte_index;
        seen.data     = out_ch.payload_byte;
        seen.has_byte = out_ch.has_byte;
        seen.last     = out_ch.last;
        seen.dropped  = out_ch.dropped_words;
        if (bytes_due.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, got addr %0d len %0d",
                   $time, seen.address, seen.length);
          failures++;
        end else begin
          want = bytes_due.pop_front();
          check_field("frame_address", 16'(want.address), 16'(seen.address));
          check_field("frame_length", 16'(want.length), 16'(seen.length));
          check_field("byte_index", 16'(want.index), 16'(seen.index));
          check_field("payload_byte", 16'(want.data), 16'(seen.data));
          check_field("has_byte", 16'(want.has_byte), 16'(seen.has_byte));
          check_field("last", 16'(want.last), 16'(seen.last));
          check_field("dropped_words", want.dropped, seen.dropped);
        end
      end
    end
    pending = bytes_due.size();
  end

endmodule

// ===== tb/sv/multidrop_9bit_frame_assembler_test.sv =====
// top of the frame assembler testbench: clock, reset, word and config stimulus,
// output stalls and the verdict; prediction lives in the checker module
`timescale 1ns / 100ps

module multidrop_9bit_frame_assembler_test;
  import mdfa_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int ERR_BURST   = 20;
  localparam int SETTLE      = 8;

  logic       clk;
  logic       rst_n;
  int         pending;
  int         failures;
  int         cycles;
  int         words_sent;
  int         run_left [2];
  bit         zero_gap;
  logic [7:0] listen_addr;

  mdfa_in_if  in_ch ();
  mdfa_out_if out_ch ();
  mdfa_cfg_if cfg_ch ();

  multidrop_9bit_frame_assembler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  multidrop_9bit_frame_assembler_checker frame_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_ch   (cfg_ch),
    .pending  (pending),
    .failures (failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // side 0 is the word sender, side 1 the result sink; occasional runs with no gaps
  function automatic int draw_gap(input int side);
    if (run_left[side] > 0) begin
      run_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run_left[side] = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic send_word(input logic is_addr, input logic [7:0] b, input logic err);
    int gap;
    gap = zero_gap ? 0 : draw_gap(0);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.is_address_word = is_addr;
    in_ch.word_byte = b;
    in_ch.receive_error = err;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic wait_frames_out();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_listen(input logic [7:0] a);
    wait_frames_out();
    cfg_ch.listen_address = a;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    listen_addr = a;
  endtask

  // address, length byte, then nbytes payload bytes with the odd bad word mixed in
  task automatic send_frame(input logic [7:0] a, input int len, input int nbytes);
    int i;
    send_word(1'b1, a, 1'b0);
    send_word(1'b0, 8'(len), 1'b0);
    for (i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1);
      send_word(1'b0, 8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic random_traffic(input int target);
    int         pick;
    int         len;
    logic [7:0] a;
    while (words_sent < target) begin
      pick = $urandom_range(0, 99);
      if (listen_addr == ADDR_ALL || $urandom_range(0, 5) == 0)
        a = 8'($urandom_range(0, 255));
      else
        a = listen_addr;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 64) : $urandom_range(0, 8);
      if (pick < 70) begin
        send_frame(a, len, len);
      end else if (pick < 80) begin
        // cut short, the next address word drops it
        send_frame(a, len, (len == 0) ? 0 : $urandom_range(0, len - 1));
      end else if (pick < 88) begin
        send_frame(a, $urandom_range(PAYLOAD_MAX + 1, 255), 0);
      end else begin
        repeat ($urandom_range(1, 3))
          send_word($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)),
                    $urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 9) == 0) wait_frames_out();
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      int stall;
      stall = draw_gap(1);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.is_address_word = 1'b0;
    in_ch.word_byte = 8'h00;
    in_ch.receive_error = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.listen_address = 8'h00;
    rst_n = 1'b0;
    zero_gap = 1'b0;
    run_left[0] = 0;
    run_left[1] = 0;
    words_sent = 0;
    listen_addr = ADDR_ALL;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed words, listening to all stations
    send_word(1'b0, 8'h00, 1'b0);
    send_word(1'b1, 8'hFF, 1'b1);
    send_word(1'b1, 8'hFF, 1'b0);
    send_word(1'b0, 8'h00, 1'b0);
    send_word(1'b1, 8'h00, 1'b0);
    send_word(1'b0, 8'd65, 1'b0);
    send_word(1'b0, 8'h12, 1'b0);
    send_word(1'b1, 8'h80, 1'b0);
    send_word(1'b0, 8'hFF, 1'b0);
    send_word(1'b1, 8'h5A, 1'b0);
    send_word(1'b0, 8'd2, 1'b0);
    send_word(1'b0, 8'hFF, 1'b0);
    send_word(1'b0, 8'h00, 1'b1);
    send_word(1'b0, 8'h00, 1'b0);
    send_word(1'b1, 8'h33, 1'b0);
    send_word(1'b0, 8'd3, 1'b0);
    send_word(1'b0, 8'hAA, 1'b0);
    send_word(1'b1, 8'h34, 1'b0);
    send_word(1'b0, 8'd1, 1'b0);
    send_word(1'b0, 8'h55, 1'b0);

    write_listen(8'h00);
    random_traffic(words_sent + 40);
    write_listen(8'($urandom_range(1, 254)));
    random_traffic(words_sent + 40);
    write_listen(ADDR_ALL);
    send_frame(8'($urandom_range(0, 255)), PAYLOAD_MAX, PAYLOAD_MAX);
    random_traffic(words_sent + 40);

    // a gapless burst of bad words, then show the drop count on a frame
    wait_frames_out();
    zero_gap = 1'b1;
    repeat (ERR_BURST)
      send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1);
    zero_gap = 1'b0;
    send_frame(8'hC3, 0, 0);
    send_frame(8'h3C, 2, 2);

    wait_frames_out();
    repeat (20) @(negedge clk);
    if (failures == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
